@@ rtl/lfu_pkg.sv @@
// Shared constants, types and handshake structs of the LFU cache table.
`default_nettype none

package lfu_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam int KEY_W   = 32;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 16;
   localparam int STAMP_W = 32;
   localparam int CAP_W   = 5;

   localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [DATA_W-1:0]  data;
      logic [COUNT_W-1:0] count;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // latch request, clear scan results
      logic issue;   // read the next slot
      logic commit;  // write back and load the response register
   } lfu_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic issue_last;
   } lfu_status_type;

endpackage

`default_nettype wire

@@ rtl/lfu_cache_table.sv @@
// Top level of the LFU cache table: stream ports, controller and datapath.
// Pacing: a new request is accepted only in idle, after the previous transaction has committed;
// the 16-entry scan through the single registered read port of the entry memory sets the pace
//   (accept, a read of each of the 16 entries, drain, commit; commit waits while a response is held).
// Reset: synchronous; clears all slot valid bits, the stamp sequence and the response
//   valid flag, and sets capacity to 16. No clearing pass; entry contents stay undefined.
`default_nettype none

module lfu_cache_table import lfu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [31:0] key, [63:32] value
   input  wire logic        req_tuser,   // [0] cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] read_value
   output logic             rsp_tuser,   // [0] found
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [4:0]  csr_data     // capacity
);

   lfu_cmd_type    cmd;
   lfu_status_type status;
   logic           cfg_we;

   assign csr_ready = 1'b1;
   assign cfg_we    = csr_valid && csr_ready;

   lfu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   lfu_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_cmd        (req_tuser),
      .req_key        (req_tdata[31:0]),
      .req_value      (req_tdata[63:32]),
      .cfg_we         (cfg_we),
      .cfg_capacity   (csr_data),
      .rsp_found      (rsp_tuser),
      .rsp_read_value (rsp_tdata)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a transaction is in flight");

   a_commit_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_tvalid || rsp_tready))
      else $error("commit would overwrite a pending response");

   a_commit_shows_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("commit did not raise response valid");

   a_load_not_commit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && (cmd.commit || cmd.issue)))
      else $error("load overlaps scan or commit");

endmodule

`default_nettype wire

@@ rtl/lfu_ctrl.sv @@
// Sequencer of the LFU cache table: accept, scan, drain, commit.
`default_nettype none

module lfu_ctrl import lfu_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output lfu_cmd_type         cmd,
   input  wire lfu_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      cmd.load   = (state_ff == ST_IDLE) && req_tvalid;
      cmd.issue  = (state_ff == ST_SCAN);
      cmd.commit = (state_ff == ST_COMMIT) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.issue_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // wait here while the previous response is still held
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.commit) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

endmodule

`default_nettype wire

@@ rtl/lfu_dpath.sv @@
// Datapath of the LFU cache table: entry memory, scan accumulators, write back.
`default_nettype none

module lfu_dpath import lfu_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lfu_cmd_type       cmd,
   output lfu_status_type         status,
   input  wire logic              req_cmd,
   input  wire logic [KEY_W-1:0]  req_key,
   input  wire logic [DATA_W-1:0] req_value,
   input  wire logic              cfg_we,
   input  wire logic [CAP_W-1:0]  cfg_capacity,
   output logic                   rsp_found,
   output logic [DATA_W-1:0]      rsp_read_value
);

   entry_type          entry_mem [MAX_ENTRIES];
   entry_type          rd_entry_ff;
   logic               slot_valid_ff [MAX_ENTRIES];

   logic [CAP_W-1:0]   capacity_ff;
   logic [STAMP_W-1:0] seq_ff;

   logic [IDX_W-1:0]   rd_idx_ff;
   logic               cmp_vld_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;

   logic               is_put_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [DATA_W-1:0]  value_ff;

   logic               hit_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic [DATA_W-1:0]  hit_data_ff;
   logic [COUNT_W-1:0] hit_count_ff;
   logic [STAMP_W-1:0] hit_stamp_ff;

   logic               vic_ff;
   logic [IDX_W-1:0]   vic_idx_ff;
   logic [COUNT_W-1:0] vic_count_ff;
   logic [STAMP_W-1:0] vic_age_ff;

   logic               free_ff;
   logic [IDX_W-1:0]   free_idx_ff;
   logic [CNT_W-1:0]   used_ff;

   logic               rsp_found_ff;
   logic [DATA_W-1:0]  rsp_data_ff;

   // compare stage
   logic               cur_valid;
   logic [STAMP_W-1:0] cur_age;
   logic               take_hit;
   logic               take_vic;
   logic               take_free;

   // commit
   logic               bump_ok;
   logic [COUNT_W-1:0] new_count;
   logic [STAMP_W-1:0] new_stamp;
   logic [31:0]        cap_lim;
   logic               full;
   logic               evict;
   logic               ins_from_vic;
   logic               ins_ok;
   logic [IDX_W-1:0]   ins_idx;
   logic               put_active;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;
   entry_type          wr_entry;
   logic               seq_adv;
   logic               clr_vic;
   logic               set_ins;

   assign status.issue_last = (rd_idx_ff == IDX_W'(MAX_ENTRIES - 1));

   assign cur_valid = slot_valid_ff[cmp_idx_ff];
   assign cur_age   = seq_ff - rd_entry_ff.stamp;   // modulo 2^32 age
   assign take_hit  = cmp_vld_ff && cur_valid && (rd_entry_ff.key == key_ff);
   assign take_free = cmp_vld_ff && !cur_valid && !free_ff;
   assign take_vic  = cmp_vld_ff && cur_valid &&
                      (!vic_ff || (rd_entry_ff.count < vic_count_ff) ||
                       ((rd_entry_ff.count == vic_count_ff) && (cur_age > vic_age_ff)));

   assign bump_ok   = (hit_count_ff != COUNT_MAX);
   assign new_count = bump_ok ? hit_count_ff + COUNT_W'(1) : hit_count_ff;
   assign new_stamp = bump_ok ? seq_ff : hit_stamp_ff;

   assign cap_lim      = (32'(capacity_ff) > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES)
                                                             : 32'(capacity_ff);
   assign full         = (32'(used_ff) >= cap_lim);
   assign evict        = full && vic_ff;
   assign ins_from_vic = evict && (!free_ff || (vic_idx_ff < free_idx_ff));
   assign ins_ok       = free_ff || evict;
   assign ins_idx      = ins_from_vic ? vic_idx_ff : free_idx_ff;
   assign put_active   = (is_put_ff == CMD_PUT) && (capacity_ff != '0);

   always_comb begin
      wr_en    = 1'b0;
      wr_idx   = hit_idx_ff;
      wr_entry = '{key: key_ff, data: value_ff, count: new_count, stamp: new_stamp};
      seq_adv  = 1'b0;
      clr_vic  = 1'b0;
      set_ins  = 1'b0;
      if (cmd.commit) begin
         if (hit_ff && ((is_put_ff == CMD_GET) || put_active)) begin
            wr_en         = 1'b1;
            wr_entry.data = (is_put_ff == CMD_PUT) ? value_ff : hit_data_ff;
            seq_adv       = bump_ok;
         end else if (!hit_ff && put_active) begin
            clr_vic = evict;
            if (ins_ok) begin
               wr_en    = 1'b1;
               set_ins  = 1'b1;
               wr_idx   = ins_idx;
               wr_entry = '{key: key_ff, data: value_ff, count: COUNT_W'(1), stamp: seq_ff};
               seq_adv  = 1'b1;
            end
         end
      end
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) entry_mem[wr_idx] <= wr_entry;
      rd_entry_ff <= entry_mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++) slot_valid_ff[i] <= 1'b0;
      end else begin
         if (clr_vic) slot_valid_ff[vic_idx_ff] <= 1'b0;
         if (set_ins) slot_valid_ff[ins_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         seq_ff      <= '0;
         cmp_vld_ff  <= 1'b0;
      end else begin
         if (cfg_we) capacity_ff <= cfg_capacity;
         if (seq_adv) seq_ff <= seq_ff + STAMP_W'(1);
         cmp_vld_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= rd_idx_ff;
      if (cmd.load) begin
         rd_idx_ff <= '0;
         is_put_ff <= req_cmd;
         key_ff    <= req_key;
         value_ff  <= req_value;
      end else if (cmd.issue) begin
         rd_idx_ff <= rd_idx_ff + IDX_W'(1);
      end

      if (cmd.load) begin
         hit_ff  <= 1'b0;
         vic_ff  <= 1'b0;
         free_ff <= 1'b0;
         used_ff <= '0;
      end else begin
         if (cmp_vld_ff && cur_valid) used_ff <= used_ff + CNT_W'(1);
         if (take_hit) begin
            hit_ff       <= 1'b1;
            hit_idx_ff   <= cmp_idx_ff;
            hit_data_ff  <= rd_entry_ff.data;
            hit_count_ff <= rd_entry_ff.count;
            hit_stamp_ff <= rd_entry_ff.stamp;
         end
         if (take_vic) begin
            vic_ff       <= 1'b1;
            vic_idx_ff   <= cmp_idx_ff;
            vic_count_ff <= rd_entry_ff.count;
            vic_age_ff   <= cur_age;
         end
         if (take_free) begin
            free_ff     <= 1'b1;
            free_idx_ff <= cmp_idx_ff;
         end
      end

      if (cmd.commit) begin
         rsp_found_ff <= hit_ff;
         rsp_data_ff  <= (hit_ff && (is_put_ff == CMD_GET)) ? hit_data_ff : '0;
      end
   end

   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_data_ff;

endmodule

`default_nettype wire

@@ tb/lfu_cache_checker.sv @@
// Checker for the LFU cache table: tracks the cache contents and compares every response.
module lfu_cache_checker import lfu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,   // [31:0] key, [63:32] value
   input  wire logic        req_tuser,   // [0] cmd
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,   // [31:0] read_value
   input  wire logic        rsp_tuser,   // [0] found
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [4:0]  csr_data,    // capacity
   output int               fail_count,
   output int               pending
);

   localparam int EXP_DEPTH = 8;

   typedef struct packed {
      logic              found;
      logic [DATA_W-1:0] read_value;
   } lookup_result_type;

   bit                 slot_valid  [MAX_ENTRIES];
   logic [KEY_W-1:0]   slot_key    [MAX_ENTRIES];
   logic [DATA_W-1:0]  slot_data   [MAX_ENTRIES];
   logic [COUNT_W-1:0] use_count   [MAX_ENTRIES];
   logic [STAMP_W-1:0] count_stamp [MAX_ENTRIES];
   logic [STAMP_W-1:0] access_seq;
   logic [CAP_W-1:0]   capacity;

   lookup_result_type exp_fifo [EXP_DEPTH];
   int                exp_head   = 0;
   int                exp_tail   = 0;
   int                exp_level  = 0;
   int                mismatches = 0;
   int                waiting    = 0;

   assign fail_count = mismatches;
   assign pending    = waiting;

   // count raise on a hit; a saturated count keeps its stamp
   function automatic void raise_count(int s);
      if (use_count[s] != COUNT_MAX) begin
         use_count[s]   = use_count[s] + 1'b1;
         count_stamp[s] = access_seq;
         access_seq     = access_seq + 1'b1;
      end
   endfunction

   function automatic lookup_result_type cache_access(logic cmd, logic [KEY_W-1:0] key,
                                                      logic [DATA_W-1:0] value);
      int                hit;
      int                free_slot;
      int                victim;
      int                used;
      int                cap;
      logic [STAMP_W-1:0] age_i;
      logic [STAMP_W-1:0] age_v;
      lookup_result_type  res;
      hit       = -1;
      free_slot = -1;
      victim    = -1;
      used      = 0;
      cap       = (capacity > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity);
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (slot_valid[i]) begin
            used++;
            if (slot_key[i] == key)
               hit = i;
            if (victim < 0) begin
               victim = i;
            end else begin
               age_i = access_seq - count_stamp[i];
               age_v = access_seq - count_stamp[victim];
               if (use_count[i] < use_count[victim] ||
                   (use_count[i] == use_count[victim] && age_i > age_v))
                  victim = i;
            end
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end

      res.found      = (hit >= 0);
      res.read_value = '0;

      if (cmd == CMD_GET) begin
         if (hit >= 0) begin
            raise_count(hit);
            res.read_value = slot_data[hit];
         end
      end else if (cap != 0) begin
         if (hit >= 0) begin
            raise_count(hit);
            slot_data[hit] = value;
         end else begin
            // full (or over-full after a capacity drop): drop exactly one victim
            if (used >= cap && victim >= 0) begin
               slot_valid[victim] = 1'b0;
               if (free_slot < 0 || victim < free_slot)
                  free_slot = victim;
            end
            if (free_slot >= 0) begin
               slot_valid[free_slot]  = 1'b1;
               slot_key[free_slot]    = key;
               slot_data[free_slot]   = value;
               use_count[free_slot]   = 1;
               count_stamp[free_slot] = access_seq;
               access_seq             = access_seq + 1'b1;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      lookup_result_type exp_rsp;
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++)
            slot_valid[i] = 1'b0;
         access_seq = '0;
         capacity   = CAP_RESET;
         exp_head   = 0;
         exp_tail   = 0;
         exp_level  = 0;
      end else begin
         if (csr_valid && csr_ready)
            capacity = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (exp_level == 0) begin
               $error("response transaction with no request outstanding");
               mismatches++;
            end else begin
               exp_rsp   = exp_fifo[exp_head];
               exp_head  = (exp_head + 1) % EXP_DEPTH;
               exp_level = exp_level - 1;
               if (rsp_tuser !== exp_rsp.found) begin
                  $error("found: expected %0d, actual %0d", exp_rsp.found, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata !== exp_rsp.read_value) begin
                  $error("read_value: expected %h, actual %h", exp_rsp.read_value, rsp_tdata);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (exp_level == EXP_DEPTH) begin
               $error("too many request transactions outstanding");
               mismatches++;
            end else begin
               exp_fifo[exp_tail] = cache_access(req_tuser, req_tdata[31:0],
                                                 req_tdata[63:32]);
               exp_tail  = (exp_tail + 1) % EXP_DEPTH;
               exp_level = exp_level + 1;
            end
         end
      end
      waiting = exp_level;
   end

endmodule

@@ tb/tb_lfu_cache_table.sv @@
// Testbench top for the LFU cache table: clock, reset, stimulus and verdict.
module tb_lfu_cache_table;
   import lfu_pkg::*;

   localparam int CYCLE_LIMIT = 4_000_000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [4:0]  csr_data;

   int          fail_count;
   int          pending;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          cycle_count    = 0;
   logic [31:0] key_pool [20];
   logic [4:0]  cap_plan [12];

   lfu_cache_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   lfu_cache_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("lfu_cache_table regression: fail");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_stall_pct);

   // called at a falling edge; returns at the falling edge after the transaction
   task automatic send_item(logic cmd, logic [31:0] key, logic [31:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {value, key};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   task automatic write_capacity(logic [4:0] cap);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_key();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return key_pool[$urandom_range(0, 3)];
         default: return key_pool[$urandom_range(0, 19)];
      endcase
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 7))
         0:       return 32'hffff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'h7fff_ffff;
         3:       return 32'h0000_0000;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_GET;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hffff_ffff;
      key_pool[2] = 32'h7fff_ffff;
      key_pool[3] = 32'h8000_0000;
      for (int i = 4; i < 20; i++)
         key_pool[i] = $urandom();
      cap_plan = '{5'd3, 5'd16, 5'd1, 5'd0, 5'd5, 5'd31,
                   5'd2, 5'd17, 5'd12, 5'd8, 5'd1, 5'd16};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty miss, extreme keys/data, data of -1, updates
      send_item(CMD_GET, 32'h0000_0000, 32'hffff_ffff);
      send_item(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
      send_item(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
      send_item(CMD_PUT, 32'hffff_ffff, 32'hffff_ffff);
      send_item(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
      send_item(CMD_GET, 32'h8000_0000, 32'h0000_0000);
      send_item(CMD_GET, 32'h7fff_ffff, 32'h0000_0000);
      send_item(CMD_GET, 32'hffff_ffff, 32'h0000_0000);
      send_item(CMD_PUT, 32'hffff_ffff, 32'h1234_5678);
      send_item(CMD_GET, 32'hffff_ffff, 32'h0000_0000);
      send_item(CMD_GET, 32'h5555_aaaa, 32'h0000_0000);
      send_item(CMD_PUT, 32'h0000_0000, 32'haaaa_5555);
      // capacity dropped below occupancy: each new key evicts exactly one
      write_capacity(5'd2);
      send_item(CMD_PUT, 32'h0000_0011, 32'h0000_0001);
      send_item(CMD_PUT, 32'h0000_0022, 32'h0000_0002);
      send_item(CMD_GET, 32'h0000_0011, 32'h0000_0000);
      send_item(CMD_GET, 32'h0000_0022, 32'h0000_0000);
      // zero capacity: puts are dropped, gets still hit
      write_capacity(5'd0);
      send_item(CMD_PUT, 32'h0000_0033, 32'h0000_0003);
      send_item(CMD_PUT, 32'h0000_0022, 32'hdead_beef);
      send_item(CMD_GET, 32'h0000_0022, 32'h0000_0000);
      send_item(CMD_GET, 32'h0000_0033, 32'h0000_0000);
      // capacity above table size
      write_capacity(5'd31);
      send_item(CMD_PUT, 32'h0000_0044, 32'h0000_0004);
      send_item(CMD_PUT, 32'h0000_0055, 32'h0000_0005);
      send_item(CMD_GET, 32'h7fff_ffff, 32'h0000_0000);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         for (int blk = 0; blk < 3; blk++) begin
            write_capacity(cap_plan[phase * 3 + blk]);
            for (int n = 0; n < 40; n++)
               send_item(logic'($urandom_range(0, 1)), rand_key(), rand_value());
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("lfu_cache_table regression: pass");
      else
         $display("lfu_cache_table regression: fail");
      $finish;
   end

endmodule
